// ===== sv/gldp_pkg.sv =====
// Shared types, sizes and helpers for the grid longest descent path block.
package gldp_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int HEIGHT_BITS = 16;

  localparam int IN_W     = 16;
  localparam int HW       = (HEIGHT_BITS < IN_W) ? HEIGHT_BITS : IN_W;
  localparam int DIM_W    = 7;
  localparam int LEN_W    = 13;
  localparam int IDX_W    = 4;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int CNT_W    = ADDR_W + 1;
  localparam int CMP_W    = 10;

  localparam int ROWS_LIM_I = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int COLS_LIM_I = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(ROWS_LIM_I);
  localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(COLS_LIM_I);
  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_GRID_ROWS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GRID_COLS = IDX_W'(1);

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [HW-1:0]     hgt_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_NORTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef struct packed {
    logic ok;
    row_t r;
    col_t c;
  } nbr_t;

  typedef struct packed {
    row_t r;
    col_t c;
    hgt_t h;
  } stk_t;

  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    dim_t res;
    res = v;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

// ===== sv/gldp_nbr.sv =====
// Neighbour locator: position and presence of one four-neighbour of a cell.
module gldp_nbr (
  input  gldp_pkg::row_t cur_r,
  input  gldp_pkg::col_t cur_c,
  input  gldp_pkg::dir_t dir,
  input  gldp_pkg::dim_t rows,
  input  gldp_pkg::dim_t cols,
  output gldp_pkg::nbr_t nbr
);

  always_comb begin
    nbr = '0;
    unique case (dir)
      gldp_pkg::DIR_EAST: begin
        nbr.ok = (gldp_pkg::cmp_t'(cur_c) + gldp_pkg::cmp_t'(1)) < gldp_pkg::cmp_t'(cols);
        nbr.r  = cur_r;
        nbr.c  = gldp_pkg::col_t'(cur_c + gldp_pkg::col_t'(1));
      end
      gldp_pkg::DIR_SOUTH: begin
        nbr.ok = (gldp_pkg::cmp_t'(cur_r) + gldp_pkg::cmp_t'(1)) < gldp_pkg::cmp_t'(rows);
        nbr.r  = gldp_pkg::row_t'(cur_r + gldp_pkg::row_t'(1));
        nbr.c  = cur_c;
      end
      gldp_pkg::DIR_NORTH: begin
        nbr.ok = (cur_r != '0);
        nbr.r  = gldp_pkg::row_t'(cur_r - gldp_pkg::row_t'(1));
        nbr.c  = cur_c;
      end
      gldp_pkg::DIR_WEST: begin
        nbr.ok = (cur_c != '0);
        nbr.r  = cur_r;
        nbr.c  = gldp_pkg::col_t'(cur_c - gldp_pkg::col_t'(1));
      end
      default: begin
        nbr = '0;
      end
    endcase
  end

endmodule

// ===== sv/grid_longest_descent_path.sv =====
// Grid longest descent path: loads a height grid and reports its longest falling path.
//
// Usage. Write grid_rows (index 0) and grid_cols (index 1) on the cfg channel; a write is
// taken when cfg_valid and cfg_ready are high, a value of 0 is stored as 1 and a value over
// the maximum as the maximum, and a write to either of them restarts loading of the grid.
// Then pulse start with one height per transaction while busy is low, row by row; heights
// load at one per cycle. After the last height of the grid busy rises and the block
// searches the grid depth first, keeping one memoised length per cell, with a single read
// port on the height and length memories and one neighbour step at a time. A neighbour
// inside the grid is read and then evaluated, and one beyond the border is skipped in its
// read step; each cell has one full pass over its neighbours, a finishing step and a scan
// read and check, and each descent into a cell adds one partial pass and a return step.
// The result appears on longest_path with done high for exactly one cycle; the receiver
// cannot stall it. busy falls in the same cycle and the next grid may load at once.
// Reset clears the sequencer, the load count and the stack pointer and sets both
// dimensions to their maxima; the memories need no clearing, since each cell's length is
// zeroed as its height loads.
module grid_longest_descent_path (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gldp_pkg::IN_W-1:0]   height,
  output logic                        busy,
  output logic                        done,
  output logic [gldp_pkg::LEN_W-1:0]  longest_path,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gldp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gldp_pkg::DIM_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    ST_LOAD     = 8'b0000_0001,
    ST_SCAN_RD  = 8'b0000_0010,
    ST_SCAN_CHK = 8'b0000_0100,
    ST_NB_RD    = 8'b0000_1000,
    ST_NB_EV    = 8'b0001_0000,
    ST_FINISH   = 8'b0010_0000,
    ST_POP      = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  gldp_pkg::dim_t  rows, rows_next;
  gldp_pkg::dim_t  cols, cols_next;
  gldp_pkg::addr_t load_count, load_count_next;
  gldp_pkg::row_t  scan_r, scan_r_next;
  gldp_pkg::col_t  scan_c, scan_c_next;
  gldp_pkg::stk_t  cur, cur_next;
  gldp_pkg::dir_t  k, k_next;
  gldp_pkg::len_t  longest, longest_next;
  gldp_pkg::len_t  best, best_next;
  gldp_pkg::cnt_t  sp, sp_next;
  gldp_pkg::row_t  nb_r, nb_r_next;
  gldp_pkg::col_t  nb_c, nb_c_next;
  logic            done_next;
  gldp_pkg::len_t  longest_path_next;

  gldp_pkg::hgt_t  h_mem [gldp_pkg::CELL_CAP];
  gldp_pkg::len_t  len_mem [gldp_pkg::CELL_CAP];
  gldp_pkg::stk_t  stk_mem [gldp_pkg::CELL_CAP];

  gldp_pkg::hgt_t  h_rd;
  gldp_pkg::len_t  len_rd;
  gldp_pkg::stk_t  stk_rd;

  logic            load_acc;
  logic            cfg_acc;
  gldp_pkg::cnt_t  cells;
  gldp_pkg::row_t  mul_r;
  gldp_pkg::col_t  mul_c;
  gldp_pkg::cnt_t  cell_full;
  gldp_pkg::addr_t cell_addr;
  gldp_pkg::nbr_t  nbr;
  logic            scan_last;
  logic            len_we;
  gldp_pkg::addr_t len_waddr;
  gldp_pkg::len_t  len_wdata;
  gldp_pkg::len_t  len_new;
  logic            stk_we;
  gldp_pkg::stk_t  stk_wdata;
  gldp_pkg::addr_t stk_raddr;

  gldp_nbr u_nbr (
    .cur_r (cur.r),
    .cur_c (cur.c),
    .dir   (k),
    .rows  (rows),
    .cols  (cols),
    .nbr   (nbr)
  );

  assign busy      = (state != ST_LOAD);
  assign cfg_ready = (state == ST_LOAD);
  assign load_acc  = start && !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cells     = gldp_pkg::cnt_t'(gldp_pkg::cnt_t'(rows) * gldp_pkg::cnt_t'(cols));
  assign cell_full = gldp_pkg::cnt_t'(gldp_pkg::cnt_t'(mul_r) * gldp_pkg::cnt_t'(cols)
                     + gldp_pkg::cnt_t'(mul_c));
  assign cell_addr = cell_full[gldp_pkg::ADDR_W-1:0];
  assign scan_last = ((gldp_pkg::cmp_t'(scan_r) + gldp_pkg::cmp_t'(1)) == gldp_pkg::cmp_t'(rows))
                  && ((gldp_pkg::cmp_t'(scan_c) + gldp_pkg::cmp_t'(1)) == gldp_pkg::cmp_t'(cols));
  assign len_new   = (longest == gldp_pkg::LEN_MAX) ? longest
                   : gldp_pkg::len_t'(longest + gldp_pkg::len_t'(1));
  assign stk_raddr = gldp_pkg::addr_t'(sp - gldp_pkg::cnt_t'(2));

  always_comb begin
    unique case (state)
      ST_NB_RD:  begin mul_r = nbr.r;  mul_c = nbr.c;  end
      ST_FINISH: begin mul_r = cur.r;  mul_c = cur.c;  end
      default:   begin mul_r = scan_r; mul_c = scan_c; end
    endcase
  end

  always_comb begin
    state_next        = state;
    rows_next         = rows;
    cols_next         = cols;
    load_count_next   = load_count;
    scan_r_next       = scan_r;
    scan_c_next       = scan_c;
    cur_next          = cur;
    k_next            = k;
    longest_next      = longest;
    best_next         = best;
    sp_next           = sp;
    nb_r_next         = nb_r;
    nb_c_next         = nb_c;
    done_next         = 1'b0;
    longest_path_next = longest_path;
    len_we            = 1'b0;
    len_waddr         = cell_addr;
    len_wdata         = '0;
    stk_we            = 1'b0;
    stk_wdata         = '0;

    unique case (state)
      ST_LOAD: begin
        if (load_acc) begin
          len_we    = 1'b1;
          len_waddr = load_count;
          if (gldp_pkg::cnt_t'(load_count) == cells - gldp_pkg::cnt_t'(1)) begin
            load_count_next = '0;
            scan_r_next     = '0;
            scan_c_next     = '0;
            best_next       = '0;
            sp_next         = '0;
            state_next      = ST_SCAN_RD;
          end else begin
            load_count_next = gldp_pkg::addr_t'(load_count + gldp_pkg::addr_t'(1));
          end
        end
        if (cfg_acc) begin
          if (cfg_index == gldp_pkg::REG_GRID_ROWS) begin
            rows_next       = gldp_pkg::clamp_dim(cfg_data, gldp_pkg::ROWS_LIM);
            load_count_next = '0;
          end else if (cfg_index == gldp_pkg::REG_GRID_COLS) begin
            cols_next       = gldp_pkg::clamp_dim(cfg_data, gldp_pkg::COLS_LIM);
            load_count_next = '0;
          end
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (len_rd == '0) begin
          stk_we       = 1'b1;
          stk_wdata    = '{r: scan_r, c: scan_c, h: h_rd};
          sp_next      = gldp_pkg::cnt_t'(1);
          cur_next     = '{r: scan_r, c: scan_c, h: h_rd};
          k_next       = gldp_pkg::DIR_EAST;
          longest_next = '0;
          state_next   = ST_NB_RD;
        end else if (scan_last) begin
          state_next = ST_DONE;
        end else begin
          if ((gldp_pkg::cmp_t'(scan_c) + gldp_pkg::cmp_t'(1)) == gldp_pkg::cmp_t'(cols)) begin
            scan_c_next = '0;
            scan_r_next = gldp_pkg::row_t'(scan_r + gldp_pkg::row_t'(1));
          end else begin
            scan_c_next = gldp_pkg::col_t'(scan_c + gldp_pkg::col_t'(1));
          end
          state_next = ST_SCAN_RD;
        end
      end
      ST_NB_RD: begin
        if (nbr.ok) begin
          nb_r_next  = nbr.r;
          nb_c_next  = nbr.c;
          state_next = ST_NB_EV;
        end else if (k == gldp_pkg::DIR_WEST) begin
          state_next = ST_FINISH;
        end else begin
          k_next = gldp_pkg::dir_t'(k + 2'd1);
        end
      end
      ST_NB_EV: begin
        if ((h_rd < cur.h) && (len_rd == '0)) begin
          stk_we       = (sp < gldp_pkg::cnt_t'(gldp_pkg::CELL_CAP));
          stk_wdata    = '{r: nb_r, c: nb_c, h: h_rd};
          sp_next      = gldp_pkg::cnt_t'(sp + gldp_pkg::cnt_t'(1));
          cur_next     = '{r: nb_r, c: nb_c, h: h_rd};
          k_next       = gldp_pkg::DIR_EAST;
          longest_next = '0;
          state_next   = ST_NB_RD;
        end else begin
          if ((h_rd < cur.h) && (len_rd > longest)) begin
            longest_next = len_rd;
          end
          if (k == gldp_pkg::DIR_WEST) begin
            state_next = ST_FINISH;
          end else begin
            k_next     = gldp_pkg::dir_t'(k + 2'd1);
            state_next = ST_NB_RD;
          end
        end
      end
      ST_FINISH: begin
        len_we    = 1'b1;
        len_wdata = len_new;
        if (len_new > best) begin
          best_next = len_new;
        end
        sp_next = gldp_pkg::cnt_t'(sp - gldp_pkg::cnt_t'(1));
        if (sp == gldp_pkg::cnt_t'(1)) begin
          if (scan_last) begin
            state_next = ST_DONE;
          end else begin
            if ((gldp_pkg::cmp_t'(scan_c) + gldp_pkg::cmp_t'(1)) == gldp_pkg::cmp_t'(cols)) begin
              scan_c_next = '0;
              scan_r_next = gldp_pkg::row_t'(scan_r + gldp_pkg::row_t'(1));
            end else begin
              scan_c_next = gldp_pkg::col_t'(scan_c + gldp_pkg::col_t'(1));
            end
            state_next = ST_SCAN_RD;
          end
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        cur_next     = stk_rd;
        k_next       = gldp_pkg::DIR_EAST;
        longest_next = '0;
        state_next   = ST_NB_RD;
      end
      ST_DONE: begin
        done_next         = 1'b1;
        longest_path_next = best;
        state_next        = ST_LOAD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      rows       <= gldp_pkg::ROWS_LIM;
      cols       <= gldp_pkg::COLS_LIM;
      load_count <= '0;
      sp         <= '0;
      best       <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      rows       <= rows_next;
      cols       <= cols_next;
      load_count <= load_count_next;
      sp         <= sp_next;
      best       <= best_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_r_next;
    scan_c       <= scan_c_next;
    cur          <= cur_next;
    k            <= k_next;
    longest      <= longest_next;
    nb_r         <= nb_r_next;
    nb_c         <= nb_c_next;
    longest_path <= longest_path_next;
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      h_mem[load_count] <= height[gldp_pkg::HW-1:0];
    end
    h_rd <= h_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rd <= len_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sp[gldp_pkg::ADDR_W-1:0]] <= stk_wdata;
    end
    stk_rd <= stk_mem[stk_raddr];
  end

  a_done_from_seq: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DONE))
    else $error("result strobe without a finished search");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= gldp_pkg::cnt_t'(gldp_pkg::CELL_CAP))
    else $error("stack pointer beyond stack depth");

  a_stack_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (sp == '0))
    else $error("stack not empty while loading");

  a_result_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (longest_path != '0))
    else $error("reported path length is zero");

endmodule

// ===== bench/tb_grid_longest_descent_path.sv =====
// Self-checking testbench for the grid longest descent path block.
`timescale 1ns / 1ps

module tb_grid_longest_descent_path;
  import gldp_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(15);
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_REPORTS  = 20;
  localparam int CELL_BUDGET  = 64;

  typedef enum int {
    PAT_UNIFORM,
    PAT_PLATEAU,
    PAT_EXTREME,
    PAT_SNAKE,
    PAT_BROKEN_SNAKE
  } pattern_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [IN_W-1:0]  height = '0;
  logic             busy;
  logic             done;
  logic [LEN_W-1:0] longest_path;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  hgt_t        grid_h   [CELL_CAP];
  int unsigned memo_len [CELL_CAP];
  bit          memo_ok  [CELL_CAP];
  int unsigned trail    [CELL_CAP];
  int unsigned grid_rows_now = MAX_ROWS;
  int unsigned grid_cols_now = MAX_COLS;
  int unsigned heights_held = 0;
  len_t        pending_lengths [$];

  int unsigned err_count = 0;
  int unsigned grids_checked = 0;
  int unsigned heights_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned burst_left = 0;

  grid_longest_descent_path uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .height       (height),
    .busy         (busy),
    .done         (done),
    .longest_path (longest_path),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic len_t longest_descent();
    int unsigned ncell, s, top, cur, nb, run, best, r, c, k;
    bit descended, has_nb;
    ncell = grid_rows_now * grid_cols_now;
    best = 0;
    for (s = 0; s < ncell; s++) begin
      memo_ok[s] = 1'b0;
    end
    for (s = 0; s < ncell; s++) begin
      if (!memo_ok[s]) begin
        top = 1;
        trail[0] = s;
        while (top > 0) begin
          cur = trail[top - 1];
          r = cur / grid_cols_now;
          c = cur % grid_cols_now;
          run = 0;
          descended = 1'b0;
          for (k = 0; k < 4; k++) begin
            if (!descended) begin
              has_nb = 1'b0;
              nb = cur;
              case (dir_t'(k))
                DIR_EAST: begin
                  has_nb = (c + 1 < grid_cols_now);
                  nb = cur + 1;
                end
                DIR_SOUTH: begin
                  has_nb = (r + 1 < grid_rows_now);
                  nb = cur + grid_cols_now;
                end
                DIR_NORTH: begin
                  has_nb = (r > 0);
                  nb = cur - grid_cols_now;
                end
                default: begin
                  has_nb = (c > 0);
                  nb = cur - 1;
                end
              endcase
              if (has_nb && grid_h[nb] < grid_h[cur]) begin
                if (!memo_ok[nb]) begin
                  trail[top] = nb;
                  top++;
                  descended = 1'b1;
                end else if (memo_len[nb] > run) begin
                  run = memo_len[nb];
                end
              end
            end
          end
          if (!descended) begin
            memo_len[cur] = run + 1;
            memo_ok[cur] = 1'b1;
            top--;
          end
        end
        if (memo_len[s] > best) begin
          best = memo_len[s];
        end
      end
    end
    if (best > 32'(LEN_MAX)) begin
      best = 32'(LEN_MAX);
    end
    return len_t'(best);
  endfunction

  function automatic void absorb_height(logic [IN_W-1:0] h);
    int unsigned ncell;
    ncell = grid_rows_now * grid_cols_now;
    if (heights_held >= ncell) begin
      heights_held = 0;
    end
    grid_h[heights_held] = hgt_t'(h);
    heights_held++;
    if (heights_held >= ncell) begin
      heights_held = 0;
      pending_lengths.push_back(longest_descent());
    end
  endfunction

  function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned top_dim);
    if (v == '0) begin
      return 1;
    end
    if (32'(v) > top_dim) begin
      return top_dim;
    end
    return 32'(v);
  endfunction

  function automatic void note_reg_write(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      REG_GRID_ROWS: begin
        grid_rows_now = fit_dim(val, MAX_ROWS);
        heights_held = 0;
      end
      REG_GRID_COLS: begin
        grid_cols_now = fit_dim(val, MAX_COLS);
        heights_held = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pattern_height(pattern_t pat, int unsigned i,
                                                     int unsigned base, bit falling);
    int unsigned r, c, pos;
    r = i / grid_cols_now;
    c = i % grid_cols_now;
    pos = r * grid_cols_now + ((r % 2 == 0) ? c : grid_cols_now - 1 - c);
    if (falling) begin
      pos = grid_rows_now * grid_cols_now - 1 - pos;
    end
    case (pat)
      PAT_PLATEAU:      return IN_W'($urandom_range(0, 3));
      PAT_EXTREME:      return $urandom_range(0, 1) ? {IN_W{1'b1}} : {IN_W{1'b0}};
      PAT_SNAKE:        return IN_W'(base + pos);
      PAT_BROKEN_SNAKE: return ($urandom_range(0, 9) == 0) ? IN_W'($urandom) : IN_W'(base + pos);
      default:          return IN_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (err_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s, got %0d expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    len_t want;
    if (!rst && done) begin
      if (pending_lengths.size() == 0) begin
        report_mismatch("result with no transaction pending", 32'(longest_path), 0);
      end else begin
        want = pending_lengths.pop_front();
        grids_checked++;
        if (longest_path !== want) begin
          report_mismatch("longest_path", 32'(longest_path), 32'(want));
        end
      end
    end
  end

  task automatic send_height(logic [IN_W-1:0] h);
    bit taken;
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    start = 1'b1;
    height = h;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1'b1;
        absorb_height(h);
        heights_sent++;
      end
      @(negedge clk);
    end
    start = 1'b0;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    bit taken;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (cfg_ready) begin
        taken = 1'b1;
        note_reg_write(idx, val);
        cfg_writes++;
      end
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // hold until every pending transaction has come back and the block is idle
  task automatic settle();
    while (pending_lengths.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_dims(logic [DIM_W-1:0] rows_val, logic [DIM_W-1:0] cols_val);
    settle();
    write_reg(REG_GRID_ROWS, rows_val);
    write_reg(REG_GRID_COLS, cols_val);
  endtask

  task automatic load_cells(pattern_t pat, int unsigned n);
    int unsigned base, i;
    bit falling;
    base = $urandom_range(0, 65535 - grid_rows_now * grid_cols_now);
    falling = 1'($urandom_range(0, 1));
    for (i = 0; i < n; i++) begin
      send_height(pattern_height(pat, i, base, falling));
    end
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:             return '0;
      1:             return DIM_W'($urandom_range(65, 127));
      2:             return DIM_W'($urandom_range(21, 64));
      3, 4, 5, 6, 7: return DIM_W'($urandom_range(7, 20));
      default:       return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  // a partial grid at the reset size must not produce a result
  task automatic test_default_size();
    load_cells(PAT_SNAKE, MAX_COLS);
  endtask

  task automatic test_directed();
    set_dims('0, '0);
    send_height('0);
    send_height({IN_W{1'b1}});
    set_dims(1, 3);
    send_height(5);
    send_height(3);
    send_height(1);
    send_height({IN_W{1'b1}});
    send_height('0);
    send_height({IN_W{1'b1}});
    set_dims(3, 1);
    send_height(1);
    send_height(2);
    send_height(3);
    set_dims(2, 2);
    repeat (4) send_height(7);
    send_height({IN_W{1'b1}});
    send_height('0);
    send_height('0);
    send_height({IN_W{1'b1}});
    // drop a partial grid with a dimension write
    send_height(9);
    send_height(8);
    send_height(7);
    settle();
    write_reg(REG_GRID_COLS, 2);
    send_height(1);
    send_height(2);
    send_height(3);
    send_height(4);
    // writes to spare indexes leave the partial grid in place
    send_height(4);
    send_height(3);
    settle();
    write_reg(REG_SPARE_LO, 5);
    write_reg(REG_SPARE_HI, '1);
    send_height(2);
    send_height(1);
  endtask

  task automatic test_dim_extremes();
    set_dims('1, 1);
    load_cells(PAT_SNAKE, grid_rows_now * grid_cols_now);
    set_dims(1, 65);
    load_cells(PAT_SNAKE, grid_rows_now * grid_cols_now);
    set_dims(64, 2);
    load_cells(PAT_UNIFORM, grid_rows_now * grid_cols_now);
    set_dims(2, 64);
    load_cells(PAT_PLATEAU, grid_rows_now * grid_cols_now);
  endtask

  task automatic test_random();
    int unsigned first, ncell, grids, g;
    logic [DIM_W-1:0] rows_val, cols_val;
    first = heights_sent;
    while (heights_sent - first < RANDOM_ITEMS) begin
      rows_val = pick_dim();
      cols_val = pick_dim();
      if (fit_dim(rows_val, MAX_ROWS) * fit_dim(cols_val, MAX_COLS) > CELL_BUDGET) begin
        cols_val = DIM_W'(CELL_BUDGET / fit_dim(rows_val, MAX_ROWS));
      end
      set_dims(rows_val, cols_val);
      ncell = grid_rows_now * grid_cols_now;
      grids = $urandom_range(1, 4);
      for (g = 0; g < grids; g++) begin
        load_cells(pattern_t'($urandom_range(0, 4)), ncell);
      end
      if (ncell > 1 && $urandom_range(0, 5) == 0) begin
        load_cells(PAT_UNIFORM, $urandom_range(1, ncell - 1));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_size();
    test_directed();
    test_dim_extremes();
    test_random();
    while (pending_lengths.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Checked %0d grids built from %0d heights, with %0d register writes.",
             grids_checked, heights_sent, cfg_writes);
    $display("Grids ran from single cells to full-length rows and columns of %0d,",
             MAX_ROWS);
    $display("with plateaus, extreme heights, snake paths and dropped partial grids.");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
